// File: rtl/fifo_writeback_block_cache_directory_macros.svh
// ----------------------------------------------------------------------------
// fifo writeback block cache directory assertion macros
// shared property wrappers for the directory checks
// ----------------------------------------------------------------------------
`ifndef FIFO_WRITEBACK_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define FIFO_WRITEBACK_BLOCK_CACHE_DIRECTORY_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FWBCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("directory check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define FWBCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("directory check failed");

`endif

// File: rtl/fwbcd_pkg.sv
// ----------------------------------------------------------------------------
// fwbcd_pkg
// types and codes shared by the cache directory modules
// ----------------------------------------------------------------------------
package fwbcd_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_SYNC  = 3'd2;
  localparam logic [2:0] CMD_CLOSE = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_WB     = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  file_id;
    logic [31:0] block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        hit;
    logic [7:0]  writeback_file;
    logic [31:0] writeback_block;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  file;
    logic [31:0] block;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } emit_t;

endpackage

// File: rtl/fwbcd_mem.sv
// ----------------------------------------------------------------------------
// fwbcd_mem
// directory entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module fwbcd_mem
  import fwbcd_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fwbcd_out.sv
// ----------------------------------------------------------------------------
// fwbcd_out
// result output register, decouples the sequencer from receiver stalls
// ----------------------------------------------------------------------------
module fwbcd_out
  import fwbcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  emit_t emit_i,
  output logic  emit_ok_o,
  output logic  rsp_valid_o,
  input  logic  rsp_stall_i,
  output rsp_t  rsp_o
);

  logic valid_q;
  rsp_t rsp_q;

  assign emit_ok_o = !valid_q || !rsp_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid) begin
      valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      rsp_q <= emit_i.rsp;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/fwbcd_ctrl.sv
// ----------------------------------------------------------------------------
// fwbcd_ctrl
// request sequencer: lookup, eviction, compaction and writeback sweeps
// ----------------------------------------------------------------------------
module fwbcd_ctrl
  import fwbcd_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  req_t             in_req_i,
  output logic             in_stall_o,
  input  logic [CAP_W-1:0] cap_i,
  input  logic             emit_ok_i,
  output emit_t            emit_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output entry_t           mem_wdata_o,
  input  entry_t           mem_rdata_i
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SWEEP,
    S_APPEND,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [7:0]    file_q, file_d;
  logic [31:0]   block_q, block_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;

  logic [CMPW-1:0] cap_ext, cnt_ext, eff_cap;
  logic            evict_need, is_access, more, hold, issue;
  logic            hit, sel, wb, drop;

  always_comb begin
    cap_ext = CMPW'(cap_i);
    cnt_ext = CMPW'(count_q);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict_need = (cnt_ext >= eff_cap) && (count_q != '0);
  assign is_access  = (cmd_q == CMD_READ) || (cmd_q == CMD_WRITE);
  assign more       = rd_idx_q < count_q;

  assign hit  = pend_q && (mem_rdata_i.file == file_q) && (mem_rdata_i.block == block_q);
  assign sel  = is_access ? (pend_idx_q == '0)
                          : ((cmd_q == CMD_FLUSH) || (mem_rdata_i.file == file_q));
  assign wb   = pend_q && sel && mem_rdata_i.dirty;
  assign drop = is_access ? sel : ((cmd_q == CMD_CLOSE) && sel);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    file_d      = file_q;
    block_d     = block_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hold        = 1'b0;
    issue       = 1'b0;
    emit_o      = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        pend_d   = 1'b0;
        rd_idx_d = '0;
        wr_idx_d = '0;
        if (in_valid_i) begin
          cmd_d   = in_req_i.command;
          file_d  = in_req_i.file_id;
          block_d = in_req_i.block_number;
          unique case (in_req_i.command)
            CMD_READ, CMD_WRITE: state_d = S_LOOKUP;
            CMD_SYNC, CMD_CLOSE, CMD_FLUSH: state_d = S_SWEEP;
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_LOOKUP: begin
        if (hit) begin
          hold = !emit_ok_i;
          if (emit_ok_i) begin
            emit_o.valid           = 1'b1;
            emit_o.rsp.result_kind = KIND_ACCESS;
            emit_o.rsp.hit         = 1'b1;
            emit_o.rsp.last        = 1'b1;
            mem_we_o               = (cmd_q == CMD_WRITE);
            mem_waddr_o            = pend_idx_q;
            mem_wdata_o            = '{file: file_q, block: block_q, dirty: 1'b1};
            state_d                = S_IDLE;
          end
        end else begin
          issue = more;
          if (!pend_q && !more) begin
            rd_idx_d = '0;
            wr_idx_d = '0;
            state_d  = evict_need ? S_SWEEP : S_APPEND;
          end
        end
      end

      S_SWEEP: begin
        hold = wb && !emit_ok_i;
        if (!hold) begin
          issue = more;
          if (pend_q) begin
            if (wb) begin
              emit_o.valid               = 1'b1;
              emit_o.rsp.result_kind     = KIND_WB;
              emit_o.rsp.writeback_file  = mem_rdata_i.file;
              emit_o.rsp.writeback_block = mem_rdata_i.block;
            end
            if (!drop) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = wr_idx_q[AW-1:0];
              mem_wdata_o = '{file:  mem_rdata_i.file,
                              block: mem_rdata_i.block,
                              dirty: mem_rdata_i.dirty & ~sel};
              wr_idx_d    = wr_idx_q + CW'(1);
            end
          end else if (!more) begin
            count_d = wr_idx_q;
            state_d = is_access ? S_APPEND : S_DONE;
          end
        end
      end

      S_APPEND: begin
        if (emit_ok_i) begin
          emit_o.valid           = 1'b1;
          emit_o.rsp.result_kind = KIND_ACCESS;
          emit_o.rsp.last        = 1'b1;
          mem_we_o               = 1'b1;
          mem_waddr_o            = count_q[AW-1:0];
          mem_wdata_o            = '{file: file_q, block: block_q,
                                     dirty: (cmd_q == CMD_WRITE)};
          count_d                = count_q + CW'(1);
          state_d                = S_IDLE;
        end
      end

      S_DONE: begin
        if (emit_ok_i) begin
          emit_o.valid           = 1'b1;
          emit_o.rsp.result_kind = KIND_DONE;
          emit_o.rsp.last        = 1'b1;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (state_q == S_LOOKUP || state_q == S_SWEEP) begin
      if (!hold) begin
        pend_d     = issue;
        pend_idx_d = rd_idx_q[AW-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
      end
    end
  end

  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_idx_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= CMD_READ;
      file_q     <= '0;
      block_q    <= '0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      file_q     <= file_d;
      block_q    <= block_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
    end
  end

endmodule

// File: rtl/fifo_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// fifo_writeback_block_cache_directory
// write-back block cache directory with fifo replacement
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i / in_stall_o / in_req_i) carries one request:
//   read or write access, sync file, close file or flush all.
//   rsp channel (rsp_valid_o / rsp_stall_i / rsp_o) returns writeback
//   requests in directory order, then one closing result with last set.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the capacity.
// sequencing:
//   a hit ends the lookup at the matching entry; a miss scans every entry,
//   then sweeps the directory when the oldest entry is evicted; sync, close
//   and flush sweep every entry.
//   one entry per cycle through the single read port of the entry memory,
//   except while a result waits for the output register.
//   a new request is taken only when the sequencer is idle; the last result
//   may still sit in the output register at that time.
// reset: directory empty, capacity 16, no clearing pass.
// stall: a held output register pauses the sweep without losing results.
// ----------------------------------------------------------------------------
module fifo_writeback_block_cache_directory
  import fwbcd_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  `include "fifo_writeback_block_cache_directory_macros.svh"

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [CAP_W-1:0] cap_q;
  emit_t            emit;
  logic             emit_ok;
  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_raddr, mem_waddr;
  entry_t           mem_wdata, mem_rdata;
  logic             acc_take;

  assign cfg_ready_o = !in_stall_o;

  assign acc_take = in_valid_i && !in_stall_o &&
                    (in_req_i.command == CMD_READ || in_req_i.command == CMD_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  fwbcd_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .cap_i       (cap_q),
    .emit_ok_i   (emit_ok),
    .emit_o      (emit),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  fwbcd_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fwbcd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .emit_ok_o   (emit_ok),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  `FWBCD_ASSERT_IMPL(a_emit_room, emit.valid, emit_ok)
  `FWBCD_ASSERT_IMPL(a_idle_quiet, !in_stall_o, !emit.valid && !mem_we)
  `FWBCD_ASSERT_NEXT(a_access_busy, acc_take, in_stall_o)

endmodule
